### hw/rtl/code_block_brace_tracker_top_defines.svh
// Assertion macros shared by the brace tracker checker.
`ifndef CODE_BLOCK_BRACE_TRACKER_TOP_DEFINES_SVH
`define CODE_BLOCK_BRACE_TRACKER_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define CBBT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define CBBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/cbbt_pkg.sv
// Types and constants of the brace tracker.
package cbbt_pkg;

    localparam logic [7:0] CHAR_OPEN  = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE = 8'h7D;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [15:0] MAX16 = 16'hFFFF;

    localparam logic [1:0] ST_CLOSED    = 2'd0;
    localparam logic [1:0] ST_UNMATCHED = 2'd1;
    localparam logic [1:0] ST_DROP_OPEN = 2'd2;
    localparam logic [1:0] ST_DROP_CLOSE = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       first_of_file;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] open_line;
        logic [31:0] close_line;
        logic [31:0] name_start;
        logic [31:0] name_end;
    } out_t;

    typedef struct packed {
        logic [31:0] open_line;
        logic [31:0] name_start;
        logic [31:0] name_end;
    } entry_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stk_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } stk_stat_t;

endpackage

### hw/rtl/cbbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbbt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/cbbt_stack.sv
// Brace stack: top two entries in registers, the rest in RAM with a prefetched read.
module cbbt_stack #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cbbt_pkg::stk_cmd_t cmd,
    input  cbbt_pkg::entry_t   push_data,
    output cbbt_pkg::entry_t   top_entry,
    output cbbt_pkg::stk_stat_t stat
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int TW = $clog2(STACK_DEPTH + 1);

    logic [TW-1:0]    top_reg;
    logic [TW-1:0]    top_cur;
    logic [TW-1:0]    top_next;
    logic             byp_reg;
    cbbt_pkg::entry_t first_reg;
    cbbt_pkg::entry_t second_reg;
    cbbt_pkg::entry_t byp_data_reg;
    cbbt_pkg::entry_t rd_data;
    cbbt_pkg::entry_t below;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;

    assign top_cur    = cmd.clear ? '0 : top_reg;
    assign stat.empty = (top_cur == '0);
    assign stat.full  = (top_cur == TW'(STACK_DEPTH));

    always_comb
    begin
        top_next = top_cur;
        if (cmd.push)
        begin
            top_next = top_cur + TW'(1);
        end
        else if (cmd.pop)
        begin
            top_next = top_cur - TW'(1);
        end
    end

    assign we    = cmd.push && (top_cur >= TW'(2));
    assign waddr = AW'(top_cur - TW'(2));
    assign raddr = AW'(top_next - TW'(3));
    assign below = byp_reg ? byp_data_reg : rd_data;
    assign top_entry = first_reg;

    cbbt_ram #(
        .WIDTH ($bits(cbbt_pkg::entry_t)),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (second_reg),
        .raddr (raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
            byp_reg <= 1'b0;
        end
        else
        begin
            top_reg <= top_next;
            byp_reg <= cmd.push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            first_reg    <= push_data;
            second_reg   <= first_reg;
            byp_data_reg <= second_reg;
        end
        else if (cmd.pop)
        begin
            first_reg  <= second_reg;
            second_reg <= below;
        end
    end

endmodule

### hw/rtl/code_block_brace_tracker_top.sv
// Brace tracker top level: one text byte per request, at most one result per byte.
// A result is registered and valid in the cycle after its byte is accepted.
// One byte per cycle unless stalled; push, pop and counters update in one step.
// The byte side stalls only while a finished result waits on a stalled output.
// Reset clears counters (line to 1), the stack pointer and result valid; RAM is kept.
module code_block_brace_tracker_top #(
    parameter int STACK_DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_valid,
    output logic           byte_stall,
    input  cbbt_pkg::in_t  byte_data,
    output logic           result_valid,
    input  logic           result_stall,
    output cbbt_pkg::out_t result_data
);

    logic                acc;
    logic                clr;
    logic                is_nl;
    logic                is_space;
    logic                is_open;
    logic                is_close;
    logic [31:0]         line_reg;
    logic [31:0]         offset_reg;
    logic [31:0]         run_reg;
    logic                prev_space_reg;
    logic [15:0]         dropped_reg;
    logic [31:0]         line_cur;
    logic [31:0]         offset_cur;
    logic [31:0]         run_cur;
    logic                prev_space_cur;
    logic [15:0]         dropped_cur;
    logic [31:0]         line_next;
    logic [31:0]         offset_next;
    logic [31:0]         run_next;
    logic [15:0]         dropped_next;
    logic                has_result;
    logic                result_valid_reg;
    cbbt_pkg::out_t      result_reg;
    cbbt_pkg::out_t      result_next;
    cbbt_pkg::stk_cmd_t  cmd;
    cbbt_pkg::stk_stat_t stat;
    cbbt_pkg::entry_t    push_data;
    cbbt_pkg::entry_t    top_entry;

    assign byte_stall   = result_valid_reg && result_stall;
    assign acc          = byte_valid && !byte_stall;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    assign clr      = byte_data.first_of_file;
    assign is_nl    = (byte_data.text_byte == cbbt_pkg::CHAR_NL);
    assign is_space = is_nl || (byte_data.text_byte == cbbt_pkg::CHAR_SPACE)
                    || (byte_data.text_byte == cbbt_pkg::CHAR_TAB);
    assign is_open  = (byte_data.text_byte == cbbt_pkg::CHAR_OPEN);
    assign is_close = (byte_data.text_byte == cbbt_pkg::CHAR_CLOSE);

    assign line_cur       = clr ? 32'd1 : line_reg;
    assign offset_cur     = clr ? '0 : offset_reg;
    assign run_cur        = clr ? '0 : run_reg;
    assign prev_space_cur = clr ? 1'b1 : prev_space_reg;
    assign dropped_cur    = clr ? '0 : dropped_reg;

    assign line_next   = (is_nl && (line_cur != cbbt_pkg::MAX32)) ? line_cur + 32'd1 : line_cur;
    assign offset_next = (offset_cur != cbbt_pkg::MAX32) ? offset_cur + 32'd1 : offset_cur;
    assign run_next    = (!is_space && prev_space_cur) ? offset_cur : run_cur;

    assign push_data.open_line  = line_next;
    assign push_data.name_start = run_cur;
    assign push_data.name_end   = offset_cur;

    assign cmd.clear = acc && clr;
    assign cmd.push  = acc && is_open && !stat.full;
    assign cmd.pop   = acc && is_close && (dropped_cur == '0) && !stat.empty;

    always_comb
    begin
        has_result              = 1'b0;
        dropped_next            = dropped_cur;
        result_next.status      = cbbt_pkg::ST_CLOSED;
        result_next.open_line   = '0;
        result_next.close_line  = line_next;
        result_next.name_start  = '0;
        result_next.name_end    = '0;
        if (is_open && stat.full)
        begin
            has_result             = 1'b1;
            if (dropped_cur != cbbt_pkg::MAX16)
            begin
                dropped_next = dropped_cur + 16'd1;
            end
            result_next.status     = cbbt_pkg::ST_DROP_OPEN;
            result_next.name_start = run_cur;
            result_next.name_end   = offset_cur;
        end
        else if (is_close)
        begin
            has_result = 1'b1;
            if (dropped_cur != '0)
            begin
                dropped_next       = dropped_cur - 16'd1;
                result_next.status = cbbt_pkg::ST_DROP_CLOSE;
            end
            else if (stat.empty)
            begin
                result_next.status = cbbt_pkg::ST_UNMATCHED;
            end
            else
            begin
                result_next.status     = cbbt_pkg::ST_CLOSED;
                result_next.open_line  = top_entry.open_line;
                result_next.name_start = top_entry.name_start;
                result_next.name_end   = top_entry.name_end;
            end
        end
    end

    cbbt_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .push_data (push_data),
        .top_entry (top_entry),
        .stat      (stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg         <= 32'd1;
            offset_reg       <= '0;
            run_reg          <= '0;
            prev_space_reg   <= 1'b1;
            dropped_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                line_reg       <= line_next;
                offset_reg     <= offset_next;
                run_reg        <= run_next;
                prev_space_reg <= is_space;
                dropped_reg    <= dropped_next;
            end
            if (!byte_stall)
            begin
                result_valid_reg <= acc && has_result;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && has_result)
        begin
            result_reg <= result_next;
        end
    end

endmodule

### hw/rtl/cbbt_checker.sv
// Port-level checker for the brace tracker, bound to the top level.
`include "code_block_brace_tracker_top_defines.svh"

module cbbt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           result_valid,
    input logic           result_stall,
    input cbbt_pkg::out_t result_data
);

    `CBBT_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result_data), "stalled result changed")
    `CBBT_ASSERT_SAME(a_closed_lines, clk, rst_n, result_valid && (result_data.status == cbbt_pkg::ST_CLOSED), (result_data.open_line != '0) && (result_data.close_line >= result_data.open_line), "closed block line order broken")
    `CBBT_ASSERT_SAME(a_open_line_zero, clk, rst_n, result_valid && (result_data.status != cbbt_pkg::ST_CLOSED), result_data.open_line == '0, "open line set on error result")
    `CBBT_ASSERT_SAME(a_name_span, clk, rst_n, result_valid && ((result_data.status == cbbt_pkg::ST_CLOSED) || (result_data.status == cbbt_pkg::ST_DROP_OPEN)), result_data.name_start <= result_data.name_end, "name span reversed")

endmodule

bind code_block_brace_tracker_top cbbt_checker u_cbbt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

### test/testbench.sv
// Self-checking testbench for the brace tracker: directed text, then random source-like streams.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES = 64;
    localparam int TARGET_BYTES = 900;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD = 500;

    class brace_scoreboard;
        logic [31:0] line_no;
        logic [31:0] offset;
        logic [31:0] word_start;
        bit after_space;
        cbbt_pkg::entry_t frames[FRAMES];
        int unsigned depth;
        logic [15:0] lost_opens;
        cbbt_pkg::out_t blocks_due[$];
        int mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            line_no = 32'd1;
            offset = '0;
            word_start = '0;
            after_space = 1'b1;
            depth = 0;
            lost_opens = '0;
        endfunction

        function int outstanding();
            return blocks_due.size();
        endfunction

        function void note_byte(cbbt_pkg::in_t req);
            logic [7:0] b;
            bit is_ws;
            bit made;
            cbbt_pkg::out_t want;
            b = req.text_byte;
            made = 1'b0;
            want = '0;
            if (req.first_of_file)
                clear();
            is_ws = (b == cbbt_pkg::CHAR_SPACE) || (b == cbbt_pkg::CHAR_TAB)
                    || (b == cbbt_pkg::CHAR_NL);
            if (b == cbbt_pkg::CHAR_NL && line_no != cbbt_pkg::MAX32)
                line_no++;
            want.close_line = line_no;
            if (b == cbbt_pkg::CHAR_OPEN)
            begin
                if (depth < FRAMES)
                begin
                    frames[depth] = '{open_line: line_no, name_start: word_start,
                                      name_end: offset};
                    depth++;
                end
                else
                begin
                    if (lost_opens != cbbt_pkg::MAX16)
                        lost_opens++;
                    want.status = cbbt_pkg::ST_DROP_OPEN;
                    want.name_start = word_start;
                    want.name_end = offset;
                    made = 1'b1;
                end
            end
            else if (b == cbbt_pkg::CHAR_CLOSE)
            begin
                made = 1'b1;
                if (lost_opens != 0)
                begin
                    lost_opens--;
                    want.status = cbbt_pkg::ST_DROP_CLOSE;
                end
                else if (depth == 0)
                begin
                    want.status = cbbt_pkg::ST_UNMATCHED;
                end
                else
                begin
                    depth--;
                    want.status = cbbt_pkg::ST_CLOSED;
                    want.open_line = frames[depth].open_line;
                    want.name_start = frames[depth].name_start;
                    want.name_end = frames[depth].name_end;
                end
            end
            if (!is_ws && after_space)
                word_start = offset;
            after_space = is_ws;
            if (offset != cbbt_pkg::MAX32)
                offset++;
            if (made)
                blocks_due.push_back(want);
        endfunction

        function void report(string what, cbbt_pkg::out_t want, cbbt_pkg::out_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch%s: want st=%0d ol=%0d cl=%0d ns=%0d ne=%0d",
                         $time, what, want.status, want.open_line, want.close_line,
                         want.name_start, want.name_end,
                         "\n                  got  st=%0d ol=%0d cl=%0d ns=%0d ne=%0d",
                         got.status, got.open_line, got.close_line,
                         got.name_start, got.name_end);
        endfunction

        function void check_result(cbbt_pkg::out_t got);
            cbbt_pkg::out_t want;
            string bad;
            if (blocks_due.size() == 0)
            begin
                report(" (no result due)", '0, got);
                return;
            end
            want = blocks_due.pop_front();
            bad = "";
            if (got.status !== want.status)
                bad = {bad, " status"};
            if (got.open_line !== want.open_line)
                bad = {bad, " open_line"};
            if (got.close_line !== want.close_line)
                bad = {bad, " close_line"};
            if (got.name_start !== want.name_start)
                bad = {bad, " name_start"};
            if (got.name_end !== want.name_end)
                bad = {bad, " name_end"};
            if (bad != "")
                report({" in", bad}, want, got);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic byte_valid = 1'b0;
    logic byte_stall;
    cbbt_pkg::in_t byte_data = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    cbbt_pkg::out_t result_data;

    brace_scoreboard book = new();
    int sent = 0;
    int cycles = 0;
    int open_cnt = 0;
    bit send_quiet = 1'b0;
    bit deep_done = 1'b0;

    code_block_brace_tracker_top #(
        .STACK_DEPTH(FRAMES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_data(byte_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
                book.note_byte(byte_data);
            if (result_valid && !result_stall)
                book.check_result(result_data);
        end
    end

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 99) == 0)
            send_quiet = !send_quiet;
        if (send_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fof);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data <= '{text_byte: b, first_of_file: fof};
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 2))
            0: return cbbt_pkg::CHAR_SPACE;
            1: return cbbt_pkg::CHAR_TAB;
            default: return cbbt_pkg::CHAR_NL;
        endcase
    endfunction

    function automatic logic [7:0] pick_word_char();
        logic [7:0] c;
        c = 8'($urandom_range(33, 126));
        if (c == cbbt_pkg::CHAR_OPEN || c == cbbt_pkg::CHAR_CLOSE)
            c = "x";
        return c;
    endfunction

    task automatic send_fragment();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_byte(pick_word_char(), 1'b0);
        n = $urandom_range(0, 3);
        repeat (n) send_byte(pick_space(), 1'b0);
        if ($urandom_range(0, 2) != 0)
        begin
            if (open_cnt > 0 && (open_cnt > 6 || $urandom_range(0, 1) == 1))
            begin
                send_byte(cbbt_pkg::CHAR_CLOSE, 1'b0);
                open_cnt--;
            end
            else
            begin
                send_byte(cbbt_pkg::CHAR_OPEN, 1'b0);
                open_cnt++;
            end
            if ($urandom_range(0, 1) == 1)
                send_byte(cbbt_pkg::CHAR_NL, 1'b0);
        end
    endtask

    task automatic send_nest(input int n, input int extra);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_byte(pick_word_char(), 1'b0);
            if ($urandom_range(0, 4) == 0)
                send_byte(pick_space(), 1'b0);
            send_byte(cbbt_pkg::CHAR_OPEN, 1'b0);
        end
        for (int i = 0; i < n + extra; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                send_byte(pick_space(), 1'b0);
            send_byte(cbbt_pkg::CHAR_CLOSE, 1'b0);
        end
    endtask

    task automatic run_directed();
        send_byte(cbbt_pkg::CHAR_CLOSE, 1'b0);
        send_byte(cbbt_pkg::CHAR_SPACE, 1'b1);
        send_text("\t{\n}");
        send_text("ab \t{ }");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(cbbt_pkg::CHAR_OPEN, 1'b1);
        send_text("x{\n{}}}");
        send_text("q {}");
    endtask

    task automatic run_random();
        int r;
        while (sent < TARGET_BYTES)
        begin
            if (!deep_done && sent >= 350)
            begin
                deep_done = 1'b1;
                send_nest($urandom_range(66, 72), $urandom_range(0, 3));
                continue;
            end
            r = $urandom_range(0, 99);
            if (r < 60)
                send_fragment();
            else if (r < 75)
                send_byte(pick_space(), 1'b0);
            else if (r < 88)
                send_byte(8'($urandom_range(0, 255)), 1'b0);
            else if (r < 93)
                send_byte(cbbt_pkg::CHAR_CLOSE, 1'b0);
            else if (r < 96)
            begin
                send_byte(8'($urandom_range(0, 255)), 1'b1);
                open_cnt = 0;
            end
            else
                send_nest($urandom_range(2, 20), $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        int n;
        bit held;
        held = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held && sent >= 250)
            begin
                held = 1'b1;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                result_stall <= 1'b0;
                @(posedge clk);
            end
            n = $urandom_range(0, 99);
            if (n < 60)
                n = 0;
            else if (n < 92)
                n = $urandom_range(1, 3);
            else
                n = $urandom_range(8, 30);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            if ($urandom_range(0, 19) == 0)
                repeat ($urandom_range(40, 150)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (book.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (book.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
